// ===== hw/rtl/icsp_pkg.sv =====
`timescale 1ns / 1ps

package icsp_pkg;

    localparam int BEAT_BYTES = 8;
    localparam int WORD_BITS  = 8 * BEAT_BYTES;
    localparam int PEND_BITS  = WORD_BITS - 8;
    localparam int WIN_BITS   = 2 * WORD_BITS - 8;
    localparam int CNT_BITS   = $clog2(BEAT_BYTES + 1);
    localparam int PC_BITS    = $clog2(BEAT_BYTES);
    localparam int SUM_BITS   = 32;

    typedef struct packed {
        logic [WORD_BITS-1:0] sum;
        logic [PEND_BITS-1:0] pend;
        logic                 raw;
        logic                 odd;
    } fold_in_t;

    // ones' complement add: carry out wraps into bit 0
    function automatic logic [WORD_BITS-1:0] add_eac(input logic [WORD_BITS-1:0] a,
                                                     input logic [WORD_BITS-1:0] b);
        logic [WORD_BITS:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            add_eac = s[WORD_BITS-1:0] + {{(WORD_BITS-1){1'b0}}, s[WORD_BITS]};
        end
    endfunction

endpackage

// ===== hw/rtl/icsp_lane.sv =====
`timescale 1ns / 1ps

module icsp_lane #(
    parameter int LANE = 0
) (
    input  logic [7:0]                   byte_in,
    input  logic                         en,
    input  logic [icsp_pkg::PC_BITS-1:0] pc,
    output logic [icsp_pkg::WIN_BITS-1:0] placed
);

    localparam int POS_BITS = icsp_pkg::PC_BITS + 1;

    logic [POS_BITS-1:0]               pos;
    logic [icsp_pkg::WIN_BITS-1:0]     ext;

    assign pos    = POS_BITS'(LANE) + {1'b0, pc};
    assign ext    = {{(icsp_pkg::WIN_BITS-8){1'b0}}, byte_in};
    assign placed = en ? (ext << {pos, 3'b000}) : '0;

endmodule

// ===== hw/rtl/icsp_align.sv =====
`timescale 1ns / 1ps

module icsp_align (
    input  logic [icsp_pkg::WORD_BITS-1:0] data,
    input  logic [icsp_pkg::CNT_BITS-1:0]  count,
    input  logic                           take_first,
    input  logic [icsp_pkg::PEND_BITS-1:0] pend,
    input  logic [icsp_pkg::PC_BITS-1:0]   pc,
    output logic [icsp_pkg::WORD_BITS-1:0] word,
    output logic                           full,
    output logic [icsp_pkg::PEND_BITS-1:0] new_pend,
    output logic [icsp_pkg::PC_BITS-1:0]   new_pc
);

    localparam int NB = icsp_pkg::BEAT_BYTES;

    logic [icsp_pkg::CNT_BITS-1:0]  n;
    logic [icsp_pkg::CNT_BITS-1:0]  m;
    logic [icsp_pkg::WORD_BITS-1:0] shifted;
    logic [icsp_pkg::CNT_BITS:0]    total;
    logic [icsp_pkg::WIN_BITS-1:0]  lane_out [NB];
    logic [icsp_pkg::WIN_BITS-1:0]  window;

    assign n       = (count > icsp_pkg::CNT_BITS'(NB)) ? icsp_pkg::CNT_BITS'(NB) : count;
    // odd leading byte is summed apart, the rest slides down one lane
    assign m       = n - {{(icsp_pkg::CNT_BITS-1){1'b0}}, take_first};
    assign shifted = take_first ? (data >> 8) : data;

    genvar i;
    generate
        for (i = 0; i < NB; i++) begin : g_lane
            icsp_lane #(.LANE(i)) u_lane (
                .byte_in (shifted[8*i +: 8]),
                .en      (icsp_pkg::CNT_BITS'(i) < m),
                .pc      (pc),
                .placed  (lane_out[i])
            );
        end
    endgenerate

    always_comb
    begin
        window = {{(icsp_pkg::WIN_BITS-icsp_pkg::PEND_BITS){1'b0}}, pend};
        for (int k = 0; k < NB; k++)
        begin
            window = window | lane_out[k];
        end
    end

    assign total    = {{(icsp_pkg::CNT_BITS-icsp_pkg::PC_BITS+1){1'b0}}, pc} + {1'b0, m};
    assign full     = total[icsp_pkg::PC_BITS];
    assign word     = window[icsp_pkg::WORD_BITS-1:0];
    assign new_pend = full ? window[icsp_pkg::WIN_BITS-1:icsp_pkg::WORD_BITS]
                           : window[icsp_pkg::PEND_BITS-1:0];
    assign new_pc   = total[icsp_pkg::PC_BITS-1:0];

endmodule

// ===== hw/rtl/icsp_fold.sv =====
`timescale 1ns / 1ps

module icsp_fold (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  icsp_pkg::fold_in_t            in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [icsp_pkg::SUM_BITS-1:0] out_data
);

    localparam int W = icsp_pkg::WORD_BITS;

    logic          c_valid_reg, d_valid_reg, e_valid_reg;
    logic          c_ready, d_ready, e_ready;
    logic [W-1:0]  c_sum_reg;
    logic          c_raw_reg, c_odd_reg;
    logic [31:0]   d_sum_reg;
    logic          d_raw_reg, d_odd_reg;
    logic [31:0]   e_sum_reg;

    logic [W-1:0]  c_sum_next;
    logic [32:0]   s33;
    logic [31:0]   d_sum_next;
    logic [16:0]   h17;
    logic [15:0]   h16;
    logic [31:0]   e_sum_next;

    assign e_ready  = !e_valid_reg || out_ready;
    assign d_ready  = !d_valid_reg || e_ready;
    assign c_ready  = !c_valid_reg || d_ready;
    assign in_ready = c_ready;

    assign c_sum_next = in_data.raw ? in_data.sum
                      : icsp_pkg::add_eac(in_data.sum, {8'h00, in_data.pend});

    // fold 64 -> 32 with end-around carry
    assign s33        = {1'b0, c_sum_reg[31:0]} + {1'b0, c_sum_reg[63:32]};
    assign d_sum_next = c_raw_reg ? c_sum_reg[31:0] : (s33[31:0] + {31'b0, s33[32]});

    // odd start: fold to 16 and swap bytes
    assign h17        = {1'b0, d_sum_reg[31:16]} + {1'b0, d_sum_reg[15:0]};
    assign h16        = h17[15:0] + {15'b0, h17[16]};
    assign e_sum_next = (d_odd_reg && !d_raw_reg) ? {16'h0000, h16[7:0], h16[15:8]} : d_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else
        begin
            if (c_ready)
            begin
                c_valid_reg <= in_valid;
            end
            if (d_ready)
            begin
                d_valid_reg <= c_valid_reg;
            end
            if (e_ready)
            begin
                e_valid_reg <= d_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_ready && in_valid)
        begin
            c_sum_reg <= c_sum_next;
            c_raw_reg <= in_data.raw;
            c_odd_reg <= in_data.odd;
        end
        if (d_ready && c_valid_reg)
        begin
            d_sum_reg <= d_sum_next;
            d_raw_reg <= c_raw_reg;
            d_odd_reg <= c_odd_reg;
        end
        if (e_ready && d_valid_reg)
        begin
            e_sum_reg <= e_sum_next;
        end
    end

    assign out_valid = e_valid_reg;
    assign out_data  = e_sum_reg;

endmodule

// ===== hw/rtl/internet_checksum_partial_top.sv =====
`timescale 1ns / 1ps
// Throughput: one beat of up to 8 bytes per clock, no bubbles between packets;
// s_tready drops only when a last beat waits on a full result pipe (m_tready low).
// The checksum reaches m_tvalid through the registers that follow the edge taking the last beat
// (registers: align, accumulate, pending add, 64->32 fold, 16-bit fold/swap + output).
// The 64-bit accumulator add with end-around carry is a per-beat loop, as is the pending state.
// Reset (rst_n, async, active low) clears all packet state and empties the pipe.
module internet_checksum_partial_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // data_word[63:0], byte_count[67:64], seed_sum[99:68], 0
    input  logic [1:0]   s_tuser,   // first_beat[0], odd_start[1]
    input  logic         s_tlast,   // last_beat
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata    // checksum[31:0]
);

    localparam int W  = icsp_pkg::WORD_BITS;
    localparam int PW = icsp_pkg::PEND_BITS;
    localparam int PC = icsp_pkg::PC_BITS;

    logic [W-1:0]                  data_word;
    logic [icsp_pkg::CNT_BITS-1:0] byte_count;
    logic [31:0]                   seed_sum;
    logic                          first_beat, odd_start, last_beat;

    logic [PW-1:0] pend_reg;
    logic [PC-1:0] pc_reg;
    logic          odd_mode_reg, fbt_reg;
    logic [W-1:0]  acc_reg;

    logic          odd_eff, fbt_eff, take_first, fbt_new;
    logic [PW-1:0] pend_eff;
    logic [PC-1:0] pc_eff;
    logic [W-1:0]  word;
    logic          full;
    logic [PW-1:0] new_pend;
    logic [PC-1:0] new_pc;
    logic [W-1:0]  term;
    logic          s_accept;

    logic          a_valid_reg, a_first_reg, a_last_reg, a_raw_reg, a_odd_reg;
    logic [W-1:0]  a_term_reg;
    logic [31:0]   a_seed_reg;
    logic [PW-1:0] a_pend_reg;
    logic          a_move;
    logic [W-1:0]  sum1;

    logic               b_valid_reg;
    icsp_pkg::fold_in_t b_reg;
    logic               b_ready, fold_ready;

    assign data_word  = s_tdata[63:0];
    assign byte_count = s_tdata[67:64];
    assign seed_sum   = s_tdata[99:68];
    assign first_beat = s_tuser[0];
    assign odd_start  = s_tuser[1];
    assign last_beat  = s_tlast;

    // a first beat starts from cleared state
    assign odd_eff    = first_beat ? odd_start : odd_mode_reg;
    assign fbt_eff    = first_beat ? 1'b0 : fbt_reg;
    assign pend_eff   = first_beat ? '0 : pend_reg;
    assign pc_eff     = first_beat ? '0 : pc_reg;
    assign take_first = odd_eff && !fbt_eff && (byte_count != '0);
    assign fbt_new    = fbt_eff || take_first;

    icsp_align u_align (
        .data       (data_word),
        .count      (byte_count),
        .take_first (take_first),
        .pend       (pend_eff),
        .pc         (pc_eff),
        .word       (word),
        .full       (full),
        .new_pend   (new_pend),
        .new_pc     (new_pc)
    );

    // pending is empty while the odd byte is still owed, so at most one term per beat
    assign term = take_first ? {{(W-16){1'b0}}, data_word[7:0], 8'h00}
                : (full ? word : '0);

    assign b_ready  = !b_valid_reg || fold_ready;
    assign a_move   = a_valid_reg && (!a_last_reg || b_ready);
    assign s_tready = !a_valid_reg || a_move;
    assign s_accept = s_tvalid && s_tready;

    assign sum1 = icsp_pkg::add_eac(a_first_reg ? {32'h0, a_seed_reg} : acc_reg, a_term_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg     <= '0;
            pc_reg       <= '0;
            odd_mode_reg <= 1'b0;
            fbt_reg      <= 1'b0;
            acc_reg      <= '0;
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s_accept)
            begin
                if (last_beat)
                begin
                    pend_reg     <= '0;
                    pc_reg       <= '0;
                    odd_mode_reg <= 1'b0;
                    fbt_reg      <= 1'b0;
                end
                else
                begin
                    pend_reg     <= new_pend;
                    pc_reg       <= new_pc;
                    odd_mode_reg <= odd_eff;
                    fbt_reg      <= fbt_new;
                end
            end
            if (s_tready)
            begin
                a_valid_reg <= s_tvalid;
            end
            if (a_move)
            begin
                acc_reg <= a_last_reg ? '0 : sum1;
            end
            if (a_move && a_last_reg)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (fold_ready)
            begin
                b_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            a_term_reg  <= term;
            a_first_reg <= first_beat;
            a_last_reg  <= last_beat;
            a_seed_reg  <= seed_sum;
            a_pend_reg  <= last_beat ? new_pend : '0;
            a_raw_reg   <= odd_eff && !fbt_new;
            a_odd_reg   <= odd_eff;
        end
        if (a_move && a_last_reg)
        begin
            b_reg.sum  <= sum1;
            b_reg.pend <= a_pend_reg;
            b_reg.raw  <= a_raw_reg;
            b_reg.odd  <= a_odd_reg;
        end
    end

    icsp_fold u_fold (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_valid_reg),
        .in_ready  (fold_ready),
        .in_data   (b_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule
